/* rtl/core/avcc_to_annexb_converter_defines.svh */
// Assertion macros shared by the avcC to Annex B converter checkers.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef AVCC_TO_ANNEXB_CONVERTER_DEFINES_SVH
`define AVCC_TO_ANNEXB_CONVERTER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define AVCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("avcc converter assertion failed");

// Condition in one cycle that requires another condition in the next cycle.
`define AVCC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("avcc converter assertion failed");

`endif

/* rtl/core/avcc_pkg.sv */
// Types and constants of the avcC to Annex B converter.
// Depends on nothing; used by the interfaces, the core modules and the checker.
package avcc_pkg;

  localparam int unsigned MAX_RES = 5;
  localparam int unsigned CNT_W   = 3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_VERSION = 2'd1,
    ST_TRUNCATED   = 2'd2
  } status_e;

  typedef enum logic [12:0] {
    PH_VERSION   = 13'b0000000000001,
    PH_HDR1      = 13'b0000000000010,
    PH_HDR2      = 13'b0000000000100,
    PH_HDR3      = 13'b0000000001000,
    PH_HDR4      = 13'b0000000010000,
    PH_HDR5      = 13'b0000000100000,
    PH_SPS_HI    = 13'b0000001000000,
    PH_SPS_LO    = 13'b0000010000000,
    PH_SPS_DATA  = 13'b0000100000000,
    PH_PPS_COUNT = 13'b0001000000000,
    PH_PPS_HI    = 13'b0010000000000,
    PH_PPS_LO    = 13'b0100000000000,
    PH_PPS_DATA  = 13'b1000000000000
  } phase_e;

  localparam logic [7:0] VERSION_ONE = 8'h01;

  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_is_data;
    logic       out_last;
    status_e    status;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } desc_t;

endpackage

/* rtl/core/avcc_ifs.sv */
// Request channel interfaces of the avcC to Annex B converter.
// Depends on avcc_pkg for the status type.
interface avcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface avcc_out_if import avcc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_last;
  status_e    status;

  modport source (output valid, out_byte, out_is_data, out_last, status, input ready);
  modport sink (input valid, out_byte, out_is_data, out_last, status, output ready);
endinterface

/* rtl/core/avcc_parse.sv */
// Record parser: walks the avcC header and builds the result list of one request.
// Depends on avcc_pkg.
module avcc_parse import avcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output desc_t      desc_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic        fin_q, fin_d;
  logic        fail_q, fail_d;

  logic        active;
  logic [15:0] len;
  logic [15:0] dec;
  logic        sc;
  logic        sc_last;
  logic        data;
  logic        data_last;
  logic        stat;
  status_e     stat_code;
  logic [CNT_W-1:0] n;

  assign active = !fin_q && !fail_q;
  assign len    = {len_hi_q, in_byte_i};
  assign dec    = rem_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    len_hi_d  = len_hi_q;
    fin_d     = fin_q;
    fail_d    = fail_q;
    sc        = 1'b0;
    sc_last   = 1'b0;
    data      = 1'b0;
    data_last = 1'b0;
    stat      = 1'b0;
    stat_code = ST_OK;
    if (active) begin
      case (phase_q)
        PH_VERSION: begin
          if (in_byte_i != VERSION_ONE) begin
            fail_d    = 1'b1;
            stat      = 1'b1;
            stat_code = ST_BAD_VERSION;
          end else begin
            phase_d = PH_HDR1;
          end
        end
        PH_HDR1: phase_d = PH_HDR2;
        PH_HDR2: phase_d = PH_HDR3;
        PH_HDR3: phase_d = PH_HDR4;
        PH_HDR4: phase_d = PH_HDR5;
        PH_HDR5: phase_d = PH_SPS_HI;
        PH_SPS_HI: begin
          len_hi_d = in_byte_i;
          phase_d  = PH_SPS_LO;
        end
        PH_SPS_LO: begin
          rem_d   = len;
          sc      = 1'b1;
          phase_d = (len == 16'd0) ? PH_PPS_COUNT : PH_SPS_DATA;
        end
        PH_SPS_DATA: begin
          data  = 1'b1;
          rem_d = dec;
          if (dec == 16'd0) begin
            phase_d = PH_PPS_COUNT;
          end
        end
        PH_PPS_COUNT: phase_d = PH_PPS_HI;
        PH_PPS_HI: begin
          len_hi_d = in_byte_i;
          phase_d  = PH_PPS_LO;
        end
        PH_PPS_LO: begin
          rem_d = len;
          sc    = 1'b1;
          if (len == 16'd0) begin
            sc_last = 1'b1;
            fin_d   = 1'b1;
          end else begin
            phase_d = PH_PPS_DATA;
          end
        end
        PH_PPS_DATA: begin
          rem_d     = dec;
          data      = 1'b1;
          data_last = (dec == 16'd0);
          if (dec == 16'd0) begin
            fin_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (in_last_i) begin
      if (!fin_d && !fail_d) begin
        stat      = 1'b1;
        stat_code = ST_TRUNCATED;
      end
      phase_d  = PH_VERSION;
      rem_d    = 16'd0;
      len_hi_d = 8'd0;
      fin_d    = 1'b0;
      fail_d   = 1'b0;
    end
  end

  always_comb begin
    desc_o.res = '0;
    n          = '0;
    if (sc) begin
      for (int i = 0; i < 4; i++) begin
        desc_o.res[i].out_byte    = START_CODE[i];
        desc_o.res[i].out_is_data = 1'b1;
        desc_o.res[i].out_last    = sc_last && (i == 3);
        desc_o.res[i].status      = ST_OK;
      end
      n = CNT_W'(4);
    end
    if (data) begin
      desc_o.res[n].out_byte    = in_byte_i;
      desc_o.res[n].out_is_data = 1'b1;
      desc_o.res[n].out_last    = data_last;
      desc_o.res[n].status      = ST_OK;
      n = n + CNT_W'(1);
    end
    if (stat) begin
      desc_o.res[n].out_byte    = 8'h00;
      desc_o.res[n].out_is_data = 1'b0;
      desc_o.res[n].out_last    = 1'b1;
      desc_o.res[n].status      = stat_code;
      n = n + CNT_W'(1);
    end
    desc_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_VERSION;
      rem_q    <= 16'd0;
      len_hi_q <= 8'd0;
      fin_q    <= 1'b0;
      fail_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      len_hi_q <= len_hi_d;
      fin_q    <= fin_d;
      fail_q   <= fail_d;
    end
  end

endmodule

/* rtl/core/avcc_emit.sv */
// Result buffer and output register: sends the results of one request one per cycle while the output is not stalled.
// Depends on avcc_pkg and avcc_out_if.
module avcc_emit import avcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  desc_t             desc_i,
  output logic              free_o,
  avcc_out_if.source        out_o
);

  res_t [MAX_RES-1:0] res_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   idx_q;
  res_t               out_q;
  logic               ovalid_q;

  logic pending;
  logic out_free;
  logic move;
  logic last_move;

  assign pending   = (idx_q != cnt_q);
  assign out_free  = !ovalid_q || out_o.ready;
  assign move      = pending && out_free;
  assign last_move = move && ((idx_q + CNT_W'(1)) == cnt_q);
  assign free_o    = !pending || last_move;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= desc_i.res;
    end
    if (move) begin
      out_q <= res_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load_i) begin
        cnt_q <= desc_i.cnt;
        idx_q <= '0;
      end else if (move) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (move) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.out_is_data = out_q.out_is_data;
  assign out_o.out_last    = out_q.out_last;
  assign out_o.status      = out_q.status;

endmodule

/* rtl/core/avcc_to_annexb_converter.sv */
// Throughput: one request per cycle while each gives at most one result and the output
// is not stalled; a request with n results holds the result buffer until all n have
// moved to the output register (the SPS and PPS length bytes give four start code bytes
// each; a truncated or bad version record adds one status result).
// Reset is asynchronous and active low; it clears the parser state and the output valid.
module avcc_to_annexb_converter import avcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  avcc_in_if.sink     in_i,
  avcc_out_if.source  out_o
);

  desc_t desc;
  logic  free;
  logic  accept;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  avcc_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .in_last_i (in_i.in_last),
    .desc_o    (desc)
  );

  avcc_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .desc_i (desc),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

/* rtl/core/avcc_checker.sv */
// Port-level checker of the avcC to Annex B converter, bound to the top level.
// Depends on avcc_pkg and the assertion macro header.
`include "avcc_to_annexb_converter_defines.svh"

module avcc_checker import avcc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_is_data_i,
  input logic       out_last_i,
  input logic [1:0] status_i
);

  `AVCC_ASSERT(a_status_only_form, out_valid_i && !out_is_data_i |-> out_last_i && out_byte_i == 8'h00 && status_i != ST_OK)
  `AVCC_ASSERT(a_data_is_ok, out_valid_i && out_is_data_i |-> status_i == ST_OK)
  `AVCC_ASSERT(a_status_known, out_valid_i |-> status_i == ST_OK || status_i == ST_BAD_VERSION || status_i == ST_TRUNCATED)
  `AVCC_ASSERT_NEXT(a_stall_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(out_last_i) && $stable(status_i))

endmodule

bind avcc_to_annexb_converter avcc_checker u_avcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .out_is_data_i (out_o.out_is_data),
  .out_last_i    (out_o.out_last),
  .status_i      (out_o.status)
);
